@@ rtl/tlsv_pkg.sv @@
// ----------------------------------------------------------------------------
// tlsv_pkg: shared types and constants of the identifier list parser
// Sizes of the entry buffer, the descriptor queue and the structs that pass
// between the front end, the queue and the emitter.
// ----------------------------------------------------------------------------
package tlsv_pkg;

  // Capacity of one field's entry buffer
  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Length prefix and byte counters
  localparam int LEN_W  = 24;
  localparam int PCNT_W = 2;

  // Two buffer banks, one per queue slot
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int BANK_W      = 1;
  localparam int ADDR_W      = BANK_W + IDX_W;
  localparam int MEM_DEPTH   = 2 ** ADDR_W;

  localparam int IDENT_W = 16;

  // Verdict on one finished field
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic              reject;
    logic [CNT_W-1:0]  count;
  } desc_t;

  // Write into the entry buffer
  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [IDENT_W-1:0] data;
  } wr_t;

endpackage

@@ rtl/tlsv_front.sv @@
// ----------------------------------------------------------------------------
// tlsv_front: byte parser of the identifier list
// Reads the length prefix, pairs body bytes into identifiers, writes them
// into the current buffer bank and hands a verdict to the queue on the
// final byte.
// ----------------------------------------------------------------------------
module tlsv_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [1:0]                cfg_data,
  input  logic                      byte_valid,
  output logic                      byte_ready,
  input  logic [7:0]                byte_data,
  input  logic                      byte_last,
  input  logic                      queue_full,
  output logic                      push,
  output tlsv_pkg::desc_t           push_desc,
  output tlsv_pkg::wr_t             wr
);

  logic [1:0]                      prefix_bytes;
  logic [tlsv_pkg::PCNT_W-1:0]     prefix_count, prefix_count_next;
  logic [tlsv_pkg::LEN_W-1:0]      declared_length, declared_length_next;
  logic [tlsv_pkg::LEN_W-1:0]      body_count, body_count_next;
  logic [7:0]                      high_half, high_half_next;
  logic [tlsv_pkg::CNT_W-1:0]      entry_count, entry_count_next;
  logic                            fault_flag, fault_flag_next;
  logic [tlsv_pkg::BANK_W-1:0]     bank;
  logic                            take;
  logic                            store;
  logic                            bad;

  assign byte_ready = !queue_full;
  assign take       = byte_valid && byte_ready;

  always_comb begin
    prefix_count_next    = prefix_count;
    declared_length_next = declared_length;
    body_count_next      = body_count;
    high_half_next       = high_half;
    entry_count_next     = entry_count;
    fault_flag_next      = fault_flag;
    store                = 1'b0;
    if (prefix_count < prefix_bytes) begin
      declared_length_next = {declared_length[tlsv_pkg::LEN_W-9:0], byte_data};
      prefix_count_next    = prefix_count + 2'd1;
    end else if (body_count >= declared_length) begin
      // Byte beyond the declared body: field is bad, counter stays put
      fault_flag_next = 1'b1;
    end else begin
      if (!body_count[0]) begin
        high_half_next = byte_data;
      end else if (entry_count < tlsv_pkg::CNT_W'(tlsv_pkg::MAX_ENTRIES)) begin
        store            = 1'b1;
        entry_count_next = entry_count + 1'b1;
      end else begin
        fault_flag_next = 1'b1;
      end
      body_count_next = body_count + 1'b1;
    end
  end

  assign bad = fault_flag_next
            || (prefix_count_next < prefix_bytes)
            || (body_count_next != declared_length_next)
            || (body_count_next == '0)
            || body_count_next[0]
            || (entry_count_next == '0);

  assign wr.en   = take && store;
  assign wr.addr = {bank, entry_count[tlsv_pkg::IDX_W-1:0]};
  assign wr.data = {high_half, byte_data};

  assign push             = take && byte_last;
  assign push_desc.bank   = bank;
  assign push_desc.reject = bad;
  assign push_desc.count  = entry_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_bytes    <= 2'd2;
      prefix_count    <= '0;
      declared_length <= '0;
      body_count      <= '0;
      high_half       <= '0;
      entry_count     <= '0;
      fault_flag      <= 1'b0;
      bank            <= '0;
    end else begin
      if (cfg_valid) begin
        prefix_bytes <= cfg_data;
      end
      if (take) begin
        if (byte_last) begin
          prefix_count    <= '0;
          declared_length <= '0;
          body_count      <= '0;
          high_half       <= '0;
          entry_count     <= '0;
          fault_flag      <= 1'b0;
          bank            <= bank + 1'b1;
        end else begin
          prefix_count    <= prefix_count_next;
          declared_length <= declared_length_next;
          body_count      <= body_count_next;
          high_half       <= high_half_next;
          entry_count     <= entry_count_next;
          fault_flag      <= fault_flag_next;
        end
      end
    end
  end

  // The body counter never runs past the declared length
  a_body_bounded: assert property (@(posedge clk) disable iff (rst)
    (prefix_count >= prefix_bytes) && (body_count > declared_length) |-> 1'b0)
    else $error("body count overran the declared length");

  a_entries_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= tlsv_pkg::CNT_W'(tlsv_pkg::MAX_ENTRIES))
    else $error("entry count beyond buffer capacity");

endmodule

@@ rtl/tlsv_queue.sv @@
// ----------------------------------------------------------------------------
// tlsv_queue: verdict queue between parser and emitter
// Holds one descriptor per buffer bank. The head stays in place while the
// emitter drains its bank, so a bank is only reused once it is free.
// ----------------------------------------------------------------------------
module tlsv_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tlsv_pkg::desc_t push_desc,
  output logic            full,
  output logic            head_valid,
  output tlsv_pkg::desc_t head,
  input  logic            pop
);

  tlsv_pkg::desc_t                 slots [tlsv_pkg::QUEUE_DEPTH];
  logic [tlsv_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tlsv_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tlsv_pkg::QCNT_W-1:0]     count;

  assign full       = (count == tlsv_pkg::QCNT_W'(tlsv_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !full)
    else $error("descriptor pushed into a full queue");

endmodule

@@ rtl/tlsv_back.sv @@
// ----------------------------------------------------------------------------
// tlsv_back: entry buffer and result emitter
// Holds the two banks of identifiers and drains the bank named by the queue
// head into the output register, or sends one reject beat.
// ----------------------------------------------------------------------------
module tlsv_back (
  input  logic                        clk,
  input  logic                        rst,
  input  tlsv_pkg::wr_t               wr,
  input  logic                        head_valid,
  input  tlsv_pkg::desc_t             head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tlsv_pkg::IDENT_W-1:0] out_ident,
  output logic                        out_accepted,
  output logic                        out_last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;

  logic [tlsv_pkg::IDENT_W-1:0] mem [tlsv_pkg::MEM_DEPTH];
  logic [tlsv_pkg::IDENT_W-1:0] rd_data;
  logic [1:0]                   state;
  logic [tlsv_pkg::IDX_W-1:0]   k;
  logic                         out_free;
  logic                         is_last;

  assign out_free = !out_valid || out_ready;
  assign is_last  = ((tlsv_pkg::CNT_W'(k) + 1'b1) == head.count);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (state == ST_FETCH) begin
      rd_data <= mem[{head.bank, k}];
    end
  end

  always_comb begin
    pop = 1'b0;
    unique case (state)
      ST_IDLE:  pop = head_valid && head.reject && out_free;
      ST_LOAD:  pop = out_free && is_last;
      default:  pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            if (head.reject) begin
              if (out_free) begin
                out_valid    <= 1'b1;
                out_ident    <= '0;
                out_accepted <= 1'b0;
                out_last     <= 1'b1;
              end
            end else begin
              k     <= '0;
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_ident    <= rd_data;
            out_accepted <= 1'b1;
            out_last     <= is_last;
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= ST_FETCH;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_busy_has_head: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> head_valid && !head.reject)
    else $error("emitter busy without an accepted field at the queue head");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (tlsv_pkg::CNT_W'(k) < head.count))
    else $error("emitter index beyond the field's entry count");

endmodule

@@ rtl/tls_u16_vector_parser.sv @@
// ----------------------------------------------------------------------------
// tls_u16_vector_parser: length-prefixed 16-bit identifier list parser
// Parses one length-prefixed field per run of bytes and emits its
// identifiers, or a single reject beat.
// ----------------------------------------------------------------------------
// Usage. Bytes of a field enter on the s_axis channel, one per beat, with
// tlast on the final byte of the field. The input side takes one byte per
// cycle while the verdict queue has room; the front end parses the prefix
// and writes identifiers into one of two buffer banks as they complete. On
// the final byte the field is judged and a verdict is queued for the emitter.
// Results leave on the m_axis channel: tdata is the identifier, tuser is 1
// for a list entry and 0 for a reject beat, tlast marks the field's final
// beat. A reject beat enters the output register once its verdict reaches
// the queue head; for a valid list the emitter reads each entry from the
// buffer (ST_FETCH) and loads it into the output (ST_LOAD) before the next.
// While the emitter drains one field, the next field can be taken in full
// into the other bank; a third field waits (s_axis_tready low) until the
// first has been drained. A stalled receiver simply holds the output
// register and, through the queue, eventually the input.
// Reset clears the parser, the queue and the output; prefix_bytes returns
// to two. The buffer needs no clearing pass. cfg_data may be written at any
// time the block is idle and acts from the next byte on.
// ----------------------------------------------------------------------------
module tls_u16_vector_parser (
  input  logic        clk,
  input  logic        rst,
  // Configuration: prefix_bytes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  // Input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // final_byte
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] ident
  output logic        m_axis_tuser,   // [0] accepted
  output logic        m_axis_tlast    // last_of_run
);

  logic            queue_full;
  logic            push;
  tlsv_pkg::desc_t push_desc;
  tlsv_pkg::wr_t   wr;
  logic            head_valid;
  tlsv_pkg::desc_t head;
  logic            pop;

  // The register is a plain flop in the front end, always writable
  assign cfg_ready = 1'b1;

  tlsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .byte_valid (s_axis_tvalid),
    .byte_ready (s_axis_tready),
    .byte_data  (s_axis_tdata),
    .byte_last  (s_axis_tlast),
    .queue_full (queue_full),
    .push       (push),
    .push_desc  (push_desc),
    .wr         (wr)
  );

  tlsv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  tlsv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_ident    (m_axis_tdata),
    .out_accepted (m_axis_tuser),
    .out_last     (m_axis_tlast)
  );

  // A reject is always a single, closing beat with a zero identifier
  a_reject_closes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("reject beat without tlast or with a non-zero identifier");

endmodule
